### design/assert_macros.svh
// assertion macros used by the receiver core design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");

// trigger in one cycle implies result in the next
`define ASSERT_NEXT(label, clk, rst_n, trig, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
        else $error("%m: check failed");

`else

`define ASSERT_ON(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, trig, res)

`endif

`endif

### design/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

    // frame geometry
    localparam int BODY_BYTES = 9;
    localparam int POS_W      = $clog2(BODY_BYTES + 2);
    localparam int IDX_W      = $clog2(BODY_BYTES);

    localparam logic [POS_W-1:0] POS_HUNT  = '0;
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CRC   = POS_W'(BODY_BYTES + 1);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT   = 2'd2;

    // configuration reset values
    localparam logic [7:0] HEADER_RESET = 8'hAA;
    localparam logic [7:0] POLY_RESET   = 8'h07;
    localparam logic [7:0] INIT_RESET   = 8'h00;

    // output stream width, 132 field bits padded to whole bytes
    localparam int TDATA_W = 136;

    // one byte waiting in the input register
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
    } t_sfr_item;

    // parser state seen by the top level
    typedef struct packed {
        logic             recompute;
        logic [POS_W-1:0] position;
    } t_sfr_status;

    // one result item
    typedef struct packed {
        logic               frame_ok;
        logic               running;
        logic               overcurrent;
        logic               overheat;
        logic               voltage_fault;
        logic [7:0]         temperature;
        logic [15:0]        angle_raw;
        logic signed [15:0] ang_speed;
        logic signed [15:0] current_raw;
        logic [7:0]         limit_applied;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } t_sfr_result;

    // crc-8 update by one byte, msb first, unreflected
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ poly;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/sfr_input_stage.sv
`timescale 1ns / 1ps

module sfr_input_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_data,
    input  logic              i_take,
    output sfr_pkg::t_sfr_item o_item
);

    logic       r_vld;
    logic [7:0] r_data;

    // free when empty or when the held byte moves on this cycle
    assign o_ready = !r_vld || i_take;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_item.vld  = r_vld;
    assign o_item.data = r_data;

endmodule

### design/sfr_parser.sv
`timescale 1ns / 1ps

module sfr_parser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfr_pkg::t_sfr_item                  i_item,
    input  logic                                i_out_free,
    output logic                                o_take,
    input  logic                                i_cfg_valid,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    output logic                                o_res_vld,
    output sfr_pkg::t_sfr_result                o_res,
    output sfr_pkg::t_sfr_status                o_status
);

    // configuration registers
    logic [7:0] r_header;
    logic [7:0] r_poly;
    logic [7:0] r_init;

    // frame state
    logic [sfr_pkg::POS_W-1:0] r_pos, n_pos;
    logic [7:0]                r_crc, n_crc;
    logic                      r_rcmp, n_rcmp;
    logic [sfr_pkg::IDX_W-1:0] r_rcnt, n_rcnt;
    logic [7:0]                r_store [sfr_pkg::BODY_BYTES];

    // held values and counters
    logic [3:0]  r_flags, n_flags;
    logic [7:0]  r_temp, n_temp;
    logic [15:0] r_angle, n_angle;
    logic [15:0] r_speed, n_speed;
    logic [15:0] r_current, n_current;
    logic [7:0]  r_limit, n_limit;
    logic [31:0] r_good, n_good;
    logic [31:0] r_bad, n_bad;

    logic       w_store_we;
    logic       w_ok;
    logic       w_cfg_crc;
    logic [7:0] w_new_init;
    logic [sfr_pkg::IDX_W-1:0] w_wr_idx;

    // no byte moves in a cycle that restarts the crc
    assign o_take = i_item.vld && i_out_free && !r_rcmp && !w_cfg_crc;

    // a polynomial or initial value write restarts the crc of a frame in flight
    assign w_cfg_crc  = i_cfg_valid &&
                        (i_cfg_index == sfr_pkg::CFG_POLY || i_cfg_index == sfr_pkg::CFG_INIT);
    assign w_new_init = (i_cfg_valid && i_cfg_index == sfr_pkg::CFG_INIT) ? i_cfg_data : r_init;
    assign w_wr_idx   = sfr_pkg::IDX_W'(r_pos - sfr_pkg::POS_FIRST);

    // configuration write transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= sfr_pkg::HEADER_RESET;
            r_poly   <= sfr_pkg::POLY_RESET;
            r_init   <= sfr_pkg::INIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfr_pkg::CFG_HEADER: r_header <= i_cfg_data;
                sfr_pkg::CFG_POLY:   r_poly   <= i_cfg_data;
                sfr_pkg::CFG_INIT:   r_init   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame parsing and crc
    always_comb begin
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_rcmp    = r_rcmp;
        n_rcnt    = r_rcnt;
        n_flags   = r_flags;
        n_temp    = r_temp;
        n_angle   = r_angle;
        n_speed   = r_speed;
        n_current = r_current;
        n_limit   = r_limit;
        n_good    = r_good;
        n_bad     = r_bad;
        w_store_we = 1'b0;
        w_ok       = 1'b0;
        o_res_vld  = 1'b0;

        if (o_take) begin
            if (r_pos == sfr_pkg::POS_HUNT) begin
                if (i_item.data == r_header) begin
                    n_pos = sfr_pkg::POS_FIRST;
                    n_crc = r_init;
                end
            end else if (r_pos == sfr_pkg::POS_CRC) begin
                // crc byte: check and unpack
                w_ok      = (r_crc == i_item.data);
                n_pos     = sfr_pkg::POS_HUNT;
                o_res_vld = 1'b1;
                if (w_ok) begin
                    n_flags   = r_store[0][3:0];
                    n_temp    = r_store[1];
                    n_angle   = {r_store[2], r_store[3]};
                    n_speed   = {r_store[4], r_store[5]};
                    n_current = {r_store[6], r_store[7]};
                    n_limit   = r_store[8];
                    n_good    = r_good + 32'd1;
                end else begin
                    n_bad = r_bad + 32'd1;
                end
            end else begin
                // body byte
                w_store_we = 1'b1;
                n_crc      = sfr_pkg::crc8_byte(r_crc, i_item.data, r_poly);
                n_pos      = r_pos + sfr_pkg::POS_W'(1);
            end
        end

        // replay of the stored body, one byte a cycle
        if (r_rcmp) begin
            n_crc  = sfr_pkg::crc8_byte(r_crc, r_store[r_rcnt], r_poly);
            n_rcnt = r_rcnt + sfr_pkg::IDX_W'(1);
            if (sfr_pkg::POS_W'(r_rcnt) + sfr_pkg::POS_W'(2) == r_pos) begin
                n_rcmp = 1'b0;
            end
        end

        if (w_cfg_crc && r_pos != sfr_pkg::POS_HUNT) begin
            n_crc  = w_new_init;
            n_rcnt = '0;
            n_rcmp = (r_pos > sfr_pkg::POS_FIRST);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= sfr_pkg::POS_HUNT;
            r_crc     <= '0;
            r_rcmp    <= 1'b0;
            r_rcnt    <= '0;
            r_flags   <= '0;
            r_temp    <= '0;
            r_angle   <= '0;
            r_speed   <= '0;
            r_current <= '0;
            r_limit   <= '0;
            r_good    <= '0;
            r_bad     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_crc     <= n_crc;
            r_rcmp    <= n_rcmp;
            r_rcnt    <= n_rcnt;
            r_flags   <= n_flags;
            r_temp    <= n_temp;
            r_angle   <= n_angle;
            r_speed   <= n_speed;
            r_current <= n_current;
            r_limit   <= n_limit;
            r_good    <= n_good;
            r_bad     <= n_bad;
        end
    end

    // body store
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[w_wr_idx] <= i_item.data;
        end
    end

    // result from the values held after this frame
    assign o_res.frame_ok      = w_ok;
    assign o_res.running       = n_flags[0];
    assign o_res.overcurrent   = n_flags[3];
    assign o_res.overheat      = n_flags[2];
    assign o_res.voltage_fault = n_flags[1];
    assign o_res.temperature   = n_temp;
    assign o_res.angle_raw     = n_angle;
    assign o_res.ang_speed     = $signed(n_speed);
    assign o_res.current_raw   = $signed(n_current);
    assign o_res.limit_applied = n_limit;
    assign o_res.good_frames   = n_good;
    assign o_res.bad_frames    = n_bad;

    assign o_status.recompute = r_rcmp;
    assign o_status.position  = r_pos;

endmodule

### design/sfr_output_stage.sv
`timescale 1ns / 1ps

module sfr_output_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_vld,
    input  sfr_pkg::t_sfr_result i_res,
    output logic                 o_free,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output sfr_pkg::t_sfr_result o_res
);

    logic                 r_vld;
    sfr_pkg::t_sfr_result r_res;

    // a new result may enter when empty or when this one leaves
    assign o_free = !r_vld || i_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_res_vld) begin
            r_vld <= 1'b1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_res_vld) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_vld;
    assign o_res    = r_res;

endmodule

### design/status_frame_receiver_core.sv
`timescale 1ns / 1ps
// status frame receiver
// s_axis carries one received serial byte per transaction. The block hunts for
// the header byte, collects the body bytes and a crc-8 byte, and checks the crc.
// Each complete frame, good or bad, gives one transaction on m_axis: tuser is
// frame_ok, tdata holds the held status values and the good and bad counts.
// Other bytes give no output.
// Throughput is one byte per cycle unless the parser stalls (output full, crc
// replay, cfg write), the crc advancing one byte per accepted byte. m_axis_tvalid
// rises when the crc byte is parsed from the input into the output register.
// The cfg channel is always ready. A polynomial or initial value write holds
// any byte in the input register for that cycle and, while a frame is in
// flight, replays the stored body through the crc, one byte a cycle, so
// s_axis_tready can stay low for the write cycle and through the replay.
// Reset clears the configuration to its defaults, returns to header hunting
// and zeroes the held values and counts; no clearing pass is needed.
// While m_axis_tready is low one result waits in the output register and the
// parser takes no byte, so s_axis takes at most one more byte and then stalls.
`include "assert_macros.svh"

module status_frame_receiver_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream, tdata: rx_byte[7:0]
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,
    // output stream, tdata from bit 0 up: running, overcurrent, overheat,
    // voltage_fault, temperature[7:0], angle_raw[15:0], ang_speed[15:0],
    // current_raw[15:0], limit_applied[7:0], good_frames[31:0],
    // bad_frames[31:0], zero padding
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sfr_pkg::TDATA_W-1:0]         m_axis_tdata,
    // tuser: frame_ok
    output logic [0:0]                          m_axis_tuser,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                          i_cfg_data
);

    sfr_pkg::t_sfr_item   w_item;
    sfr_pkg::t_sfr_status w_status;
    sfr_pkg::t_sfr_result w_res;
    sfr_pkg::t_sfr_result w_out;
    logic                 w_take;
    logic                 w_res_vld;
    logic                 w_out_free;

    assign o_cfg_ready = 1'b1;

    // input register
    sfr_input_stage u_input (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // frame parser
    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (w_item),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_vld   (w_res_vld),
        .o_res       (w_res),
        .o_status    (w_status)
    );

    // output register
    sfr_output_stage u_output (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_res_vld (w_res_vld),
        .i_res     (w_res),
        .o_free    (w_out_free),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_res     (w_out)
    );

    // pack the result fields
    assign m_axis_tdata = {4'b0000,
                           w_out.bad_frames,
                           w_out.good_frames,
                           w_out.limit_applied,
                           w_out.current_raw,
                           w_out.ang_speed,
                           w_out.angle_raw,
                           w_out.temperature,
                           w_out.voltage_fault,
                           w_out.overheat,
                           w_out.overcurrent,
                           w_out.running};
    assign m_axis_tuser = w_out.frame_ok;

    // checks
    `ASSERT_ON(a_pos_range, i_clk, i_rst_n, w_status.position <= sfr_pkg::POS_CRC)
    `ASSERT_ON(a_replay_pos, i_clk, i_rst_n, !w_status.recompute || w_status.position > sfr_pkg::POS_FIRST)
    `ASSERT_ON(a_no_take_replay, i_clk, i_rst_n, !(w_status.recompute && w_take))
    `ASSERT_NEXT(a_result_out, i_clk, i_rst_n, w_res_vld, m_axis_tvalid)

endmodule

### test/tb_status_frame_receiver_core.sv
`timescale 1ns / 1ps

module tb_status_frame_receiver_core;

    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_BYTES = 150;

    typedef logic [7:0] t_frame_bytes [sfr_pkg::BODY_BYTES+1];

    // dut ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sfr_pkg::TDATA_W-1:0]     m_axis_tdata;
    logic [0:0]                      m_axis_tuser;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [sfr_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [7:0]                      i_cfg_data = '0;

    // register settings per phase, phase 4 is drawn at random
    logic [7:0] plan_hdr  [NUM_PHASES] = '{8'hAA, 8'h00, 8'hFF, 8'h7E, 8'h00, 8'hAA};
    logic [7:0] plan_poly [NUM_PHASES] = '{8'h07, 8'hFF, 8'h00, 8'h31, 8'h00, 8'h07};
    logic [7:0] plan_seed [NUM_PHASES] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};

    // bytes waiting for the serial side and frame reports waiting for the dut
    logic [7:0]           rx_bytes_q [$];
    sfr_pkg::t_sfr_result frame_reports_q [$];

    // predictor copy of the registers and parser state
    logic [7:0]           hdr_value = sfr_pkg::HEADER_RESET;
    logic [7:0]           crc_poly  = sfr_pkg::POLY_RESET;
    logic [7:0]           crc_seed  = sfr_pkg::INIT_RESET;
    int                   parse_pos = 0;
    t_frame_bytes         frame_bytes = '{default: '0};
    sfr_pkg::t_sfr_result held_report = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int bytes_sent    = 0;
    int good_seen     = 0;
    int bad_seen      = 0;
    int queued_bytes  = 0;

    status_frame_receiver_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // crc-8 over the body bytes, msb first, no reflection, no final xor
    function automatic logic [7:0] body_crc(input t_frame_bytes fb,
                                            input logic [7:0] poly,
                                            input logic [7:0] seed);
        logic [7:0] c;
        c = seed;
        for (int i = 0; i < sfr_pkg::BODY_BYTES; i++) begin
            c = c ^ fb[i];
            for (int k = 0; k < 8; k++) begin
                if (c[7]) begin
                    c = {c[6:0], 1'b0} ^ poly;
                end else begin
                    c = {c[6:0], 1'b0};
                end
            end
        end
        return c;
    endfunction

    // parser prediction for one accepted byte
    task automatic advance_parser(input logic [7:0] rx);
        logic ok;
        if (parse_pos == 0) begin
            if (rx == hdr_value) begin
                parse_pos = 1;
            end
        end else begin
            frame_bytes[parse_pos-1] = rx;
            parse_pos++;
            if (parse_pos > sfr_pkg::BODY_BYTES + 1) begin
                parse_pos = 0;
                ok = (body_crc(frame_bytes, crc_poly, crc_seed) ==
                      frame_bytes[sfr_pkg::BODY_BYTES]);
                if (ok) begin
                    held_report.running       = frame_bytes[0][0];
                    held_report.voltage_fault = frame_bytes[0][1];
                    held_report.overheat      = frame_bytes[0][2];
                    held_report.overcurrent   = frame_bytes[0][3];
                    held_report.temperature   = frame_bytes[1];
                    held_report.angle_raw     = {frame_bytes[2], frame_bytes[3]};
                    held_report.ang_speed     = {frame_bytes[4], frame_bytes[5]};
                    held_report.current_raw   = {frame_bytes[6], frame_bytes[7]};
                    held_report.limit_applied = frame_bytes[8];
                    held_report.good_frames   = held_report.good_frames + 32'd1;
                end else begin
                    held_report.bad_frames = held_report.bad_frames + 32'd1;
                end
                held_report.frame_ok = ok;
                frame_reports_q.push_back(held_report);
            end
        end
    endtask

    // serial side driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                advance_parser(s_axis_tdata);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (rx_bytes_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= rx_bytes_q.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // frame report monitor
    always @(posedge i_clk) begin
        sfr_pkg::t_sfr_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_reports_q.size() == 0) begin
                    $display("%0t: unexpected frame report, expected none actual %h/%h",
                             $time, m_axis_tuser, m_axis_tdata);
                    error_count++;
                end else begin
                    want = frame_reports_q.pop_front();
                    if (want.frame_ok) good_seen++;
                    else bad_seen++;
                    compare_field("frame_ok", 32'(want.frame_ok), 32'(m_axis_tuser[0]));
                    compare_field("running", 32'(want.running), 32'(m_axis_tdata[0]));
                    compare_field("overcurrent", 32'(want.overcurrent),
                                  32'(m_axis_tdata[1]));
                    compare_field("overheat", 32'(want.overheat), 32'(m_axis_tdata[2]));
                    compare_field("voltage_fault", 32'(want.voltage_fault),
                                  32'(m_axis_tdata[3]));
                    compare_field("temperature", 32'(want.temperature),
                                  32'(m_axis_tdata[11:4]));
                    compare_field("angle_raw", 32'(want.angle_raw),
                                  32'(m_axis_tdata[27:12]));
                    compare_field("ang_speed", 32'($unsigned(want.ang_speed)),
                                  32'(m_axis_tdata[43:28]));
                    compare_field("current_raw", 32'($unsigned(want.current_raw)),
                                  32'(m_axis_tdata[59:44]));
                    compare_field("limit_applied", 32'(want.limit_applied),
                                  32'(m_axis_tdata[67:60]));
                    compare_field("good_frames", want.good_frames, m_axis_tdata[99:68]);
                    compare_field("bad_frames", want.bad_frames, m_axis_tdata[131:100]);
                end
            end
        end
    end

    // stimulus helpers
    task automatic queue_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        queued_bytes++;
    endtask

    function automatic logic [7:0] pick_body_byte();
        case ($urandom_range(9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return hdr_value;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_frame(input t_frame_bytes fb, input bit corrupt);
        logic [7:0] c;
        c = body_crc(fb, crc_poly, crc_seed);
        if (corrupt) c = c ^ 8'($urandom_range(1, 255));
        queue_byte(hdr_value);
        for (int i = 0; i < sfr_pkg::BODY_BYTES; i++) queue_byte(fb[i]);
        queue_byte(c);
    endtask

    task automatic write_reg(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            sfr_pkg::CFG_HEADER: hdr_value = val;
            sfr_pkg::CFG_POLY:   crc_poly  = val;
            sfr_pkg::CFG_INIT:   crc_seed  = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_reports_q.size() != 0);
    endtask

    // run limit
    initial begin
        #(2_000_000);
        $display("status_frame_receiver_core: mismatch");
        $finish;
    end

    // phases: register setting, then directed and random byte streams
    initial begin
        t_frame_bytes fb;
        int           pick;
        logic [7:0]   b;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender and receiver stall rates change every two phases
            send_idle_pct = (p < 2) ? 31 : (p < 4) ? 78 : 0;
            recv_idle_pct = (p < 2) ? 78 : (p < 4) ? 31 : 0;

            if (p > 0) begin
                wait_idle();
                repeat (4) @(posedge i_clk);
                if (p == 4) begin
                    plan_hdr[p]  = 8'($urandom);
                    plan_poly[p] = 8'($urandom);
                    plan_seed[p] = 8'($urandom);
                end
                write_reg(sfr_pkg::CFG_HEADER, plan_hdr[p]);
                write_reg(sfr_pkg::CFG_POLY, plan_poly[p]);
                write_reg(sfr_pkg::CFG_INIT, plan_seed[p]);
                if (p == 1) write_reg(CFG_UNUSED, 8'h5A);
            end else begin
                // directed: stray byte, all-ones frame, false start with bad crc
                queue_byte(8'h55);
                fb = '{default: 8'hFF};
                queue_frame(fb, 1'b0);
                fb = '{default: 8'h00};
                fb[0] = hdr_value;
                queue_frame(fb, 1'b1);
            end

            queued_bytes = 0;
            while (queued_bytes < PHASE_BYTES) begin
                pick = $urandom_range(99);
                for (int i = 0; i <= sfr_pkg::BODY_BYTES; i++) fb[i] = pick_body_byte();
                if (pick < 75) begin
                    queue_frame(fb, 1'b0);
                end else if (pick < 87) begin
                    queue_frame(fb, 1'b1);
                end else if (pick < 94) begin
                    // line noise between frames
                    b = 8'($urandom);
                    if (b == hdr_value) b = ~b;
                    queue_byte(b);
                end else begin
                    // frame cut short, the bytes that follow are parsed as the rest of it
                    queue_byte(hdr_value);
                    for (int i = 0; i < $urandom_range(1, sfr_pkg::BODY_BYTES); i++) begin
                        queue_byte(fb[i]);
                    end
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (frame_reports_q.size() != 0) begin
            $display("%0t: %0d frame reports never arrived", $time, frame_reports_q.size());
            error_count++;
        end

        $display("sent %0d serial bytes over %0d register settings with varied stalls,",
                 bytes_sent, NUM_PHASES);
        $display("checked %0d frame reports (%0d crc good, %0d crc bad), %0d errors",
                 good_seen + bad_seen, good_seen, bad_seen, error_count);
        if (error_count == 0) begin
            $display("status_frame_receiver_core: match");
        end else begin
            $display("status_frame_receiver_core: mismatch");
        end
        $finish;
    end

endmodule
